FILE: rtl/mesh_distance_parity_embedder_core_assert.svh
// Assertion macros for the mesh distance-parity embedder
`ifndef MESH_DISTANCE_PARITY_EMBEDDER_CORE_ASSERT_SVH
`define MESH_DISTANCE_PARITY_EMBEDDER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MDPE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mdpe assertion failed");

// next-cycle implication, checked out of reset
`define MDPE_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mdpe assertion failed");

`endif

FILE: rtl/mdpe_pkg.sv
// Shared widths, register indexes and sequencer codes of the embedder
`default_nettype none
package mdpe_pkg;
    localparam int COORD_W = 32;   // vertex coordinate
    localparam int DIFF_W  = 33;   // coordinate difference
    localparam int CFG_W   = 20;   // configuration register
    localparam int SQ_W    = 66;   // sum of three squares
    localparam int RAD_W   = 68;   // radicand, padded to an even width
    localparam int ROOT_W  = 34;   // integer root
    localparam int SREM_W  = 37;   // root remainder
    localparam int NUM_W   = 54;   // divider numerator
    localparam int DV_W    = 35;   // divider divisor
    localparam int Q_W     = 21;   // kept quotient bits
    localparam int MV_W    = 22;   // signed displacement
    localparam int CNT_W   = 6;    // iteration counter

    localparam int ROOT_ITERS = ROOT_W;
    localparam int NUDGE_ITERS = NUM_W;
    localparam int PAR_ITERS = ROOT_W;

    localparam logic [CFG_W-1:0] STEP_RST = CFG_W'(1000);
    localparam logic [CFG_W-1:0] UNIT_RST = CFG_W'(1000);

    // configuration register indexes
    localparam logic REG_STEP_SIZE   = 1'b0;
    localparam logic REG_PARITY_UNIT = 1'b1;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_SQRT = 4'd2;
    localparam logic [3:0] S_ROOT = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_NLD  = 4'd5;
    localparam logic [3:0] S_PLD  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_MOVE = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;
endpackage
`default_nettype wire

FILE: rtl/mesh_distance_parity_embedder_core.sv
// Mesh distance-parity embedder: sequencer around a shared multiplier, root and divider
// One vertex is taken at a time and the input stalls until its result word is taken.
// A first vertex, or one with no bit or no predecessor, skips straight to its result.
// Otherwise it passes through the shared bit-serial units: the squared distance and its
// root, the three displacement divisions and the parity division, then for each move the
// squares, the root and the parity division again.
`default_nettype none
module mesh_distance_parity_embedder_core #(
    parameter int MAX_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_idx,
    input  logic [mdpe_pkg::CFG_W-1:0]    i_cfg_wdata,
    // input words
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [mdpe_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [mdpe_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [mdpe_pkg::COORD_W-1:0] i_point_z,
    input  logic                          i_embed_bit,
    input  logic                          i_has_bit,
    input  logic                          i_first_point,
    // result words
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [mdpe_pkg::COORD_W-1:0] o_out_x,
    output logic signed [mdpe_pkg::COORD_W-1:0] o_out_y,
    output logic signed [mdpe_pkg::COORD_W-1:0] o_out_z,
    output logic [4:0]                    o_steps_taken,
    output logic                          o_embed_failed
);
    import mdpe_pkg::*;

    localparam int SW = $clog2(MAX_STEPS + 1);

    logic [3:0]                r_state;
    logic [CFG_W-1:0]          r_step, r_unit;
    logic signed [COORD_W-1:0] r_x, r_y, r_z, r_px, r_py, r_pz;
    logic                      r_have_prev, r_bit, r_pass, r_failed;
    logic [SW-1:0]             r_steps;
    logic [1:0]                r_comp;
    logic [CNT_W-1:0]          r_cnt;
    logic [63:0]               r_prod;
    logic [SQ_W-1:0]           r_acc;
    logic [RAD_W-1:0]          r_rad;
    logic [SREM_W-1:0]         r_srem;
    logic [ROOT_W-1:0]         r_root, r_d, r_cur;
    logic [NUM_W-1:0]          r_dn;
    logic [DV_W-1:0]           r_dv;
    logic [DV_W-1:0]           r_rem;
    logic [Q_W-1:0]            r_q;
    logic signed [MV_W-1:0]    r_mx, r_my, r_mz;

    logic in_acc, out_acc;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // differences to the previous vertex and their magnitudes
    logic [DIFF_W-1:0] dif [3];
    logic [COORD_W-1:0] adif [3];
    assign dif[0] = {r_x[COORD_W-1], r_x} - {r_px[COORD_W-1], r_px};
    assign dif[1] = {r_y[COORD_W-1], r_y} - {r_py[COORD_W-1], r_py};
    assign dif[2] = {r_z[COORD_W-1], r_z} - {r_pz[COORD_W-1], r_pz};
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            adif[k] = dif[k][DIFF_W-1] ? COORD_W'(-dif[k]) : dif[k][COORD_W-1:0];
        end
    end

    // shared multiplier: squares or magnitude times step size
    logic [COORD_W-1:0] mul_a, mul_b;
    logic [63:0]        mul_p;
    logic [1:0]         csel;
    assign csel  = (r_comp == 2'd3) ? 2'd2 : r_comp;
    assign mul_a = adif[csel];
    assign mul_b = (r_state == S_SQ) ? adif[csel] : {{(COORD_W-CFG_W){1'b0}}, r_step};
    assign mul_p = mul_a * mul_b;

    logic [SQ_W-1:0] acc_sum;
    assign acc_sum = r_acc + {2'b0, r_prod};

    // one root step per cycle
    logic [SREM_W-1:0] srem_sh, strial;
    logic              sge;
    assign srem_sh = {r_srem[SREM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign strial  = {1'b0, r_root, 2'b01};
    assign sge     = srem_sh >= strial;

    // one quotient bit per cycle
    logic [DV_W:0] drem_sh;
    logic          dge;
    logic [Q_W-1:0] q_next;
    assign drem_sh = {r_rem, r_dn[NUM_W-1]};
    assign dge     = drem_sh >= {1'b0, r_dv};
    assign q_next  = {r_q[Q_W-2:0], dge};

    // signed displacement from the finished quotient
    logic               mv_neg;
    logic signed [MV_W-1:0] mv;
    assign mv_neg = dif[csel][DIFF_W-1] ^ ~r_bit;
    assign mv     = mv_neg ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});

    logic [CFG_W-1:0] unit_eff;
    assign unit_eff = (r_unit == '0) ? CFG_W'(1) : r_unit;

    // saturating move of one coordinate
    function automatic logic signed [COORD_W-1:0] move_sat(
        input logic signed [COORD_W-1:0] c, input logic signed [MV_W-1:0] m);
        logic signed [COORD_W+1:0] s;
        begin
            s = {{2{c[COORD_W-1]}}, c} + {{(COORD_W+2-MV_W){m[MV_W-1]}}, m};
            if (s > $signed({3'b0, {(COORD_W-1){1'b1}}}))
                move_sat = {1'b0, {(COORD_W-1){1'b1}}};
            else if (s < $signed({3'b111, {(COORD_W-1){1'b0}}}))
                move_sat = {1'b1, {(COORD_W-1){1'b0}}};
            else
                move_sat = s[COORD_W-1:0];
        end
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RST;
            r_unit <= UNIT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_STEP_SIZE:   r_step <= i_cfg_wdata;
                REG_PARITY_UNIT: r_unit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // previous vertex, taken from each delivered word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_pz <= '0;
            r_have_prev <= 1'b0;
        end else if (out_acc) begin
            r_px <= r_x;
            r_py <= r_y;
            r_pz <= r_z;
            r_have_prev <= 1'b1;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_comp  <= '0;
            r_cnt   <= '0;
            r_steps <= '0;
            r_failed <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_x <= i_point_x;
                        r_y <= i_point_y;
                        r_z <= i_point_z;
                        r_bit <= i_embed_bit;
                        r_steps <= '0;
                        r_failed <= 1'b0;
                        r_pass <= 1'b0;
                        r_comp <= '0;
                        if (i_first_point || !r_have_prev || !i_has_bit)
                            r_state <= S_OUT;
                        else
                            r_state <= S_SQ;
                    end
                end
                // three squares through the multiplier, summed one behind
                S_SQ: begin
                    r_prod <= mul_p;
                    r_acc <= (r_comp == 2'd0) ? '0 : acc_sum;
                    if (r_comp == 2'd3) begin
                        r_rad <= {2'b0, acc_sum};
                        r_srem <= '0;
                        r_root <= '0;
                        r_cnt <= CNT_W'(ROOT_ITERS);
                        r_state <= S_SQRT;
                    end else begin
                        r_comp <= r_comp + 2'd1;
                    end
                end
                S_SQRT: begin
                    r_srem <= sge ? srem_sh - strial : srem_sh;
                    r_root <= {r_root[ROOT_W-2:0], sge};
                    r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1))
                        r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_cur <= r_root;
                    r_comp <= '0;
                    if (r_pass) begin
                        r_state <= S_PLD;
                    end else if (r_root == '0) begin
                        r_failed <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_d <= r_root;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= mul_p;
                    r_state <= S_NLD;
                end
                // numerator 2*num + d over divisor 2*d rounds to nearest
                S_NLD: begin
                    r_dn <= {r_prod[NUM_W-3:0], 1'b0} + {{(NUM_W-ROOT_W){1'b0}}, r_d};
                    r_dv <= {r_d, 1'b0};
                    r_rem <= '0;
                    r_q <= '0;
                    r_cnt <= CNT_W'(NUDGE_ITERS);
                    r_state <= S_DIV;
                end
                // parity division: distance over the quantum, numerator left aligned
                S_PLD: begin
                    r_dn <= {r_cur, {(NUM_W-ROOT_W){1'b0}}};
                    r_dv <= {{(DV_W-CFG_W){1'b0}}, unit_eff};
                    r_rem <= '0;
                    r_q <= '0;
                    r_cnt <= CNT_W'(PAR_ITERS);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= dge ? DV_W'(drem_sh - {1'b0, r_dv}) : drem_sh[DV_W-1:0];
                    r_q   <= q_next;
                    r_dn  <= {r_dn[NUM_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        if (r_state == S_DIV && r_dv[DV_W-1:CFG_W] == '0 && r_comp == 2'd3) begin
                            // parity result: quotient low bit against the wanted bit
                            r_comp <= '0;
                            if (dge == r_bit) begin
                                r_state <= S_OUT;
                            end else if (r_steps == SW'(MAX_STEPS)) begin
                                r_failed <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_MOVE;
                            end
                        end else begin
                            unique case (r_comp)
                                2'd0: r_mx <= mv;
                                2'd1: r_my <= mv;
                                default: r_mz <= mv;
                            endcase
                            r_comp <= r_comp + 2'd1;
                            r_state <= (r_comp == 2'd2) ? S_PLD : S_MUL;
                        end
                    end
                end
                S_MOVE: begin
                    r_x <= move_sat(r_x, r_mx);
                    r_y <= move_sat(r_y, r_my);
                    r_z <= move_sat(r_z, r_mz);
                    r_steps <= r_steps + 1'b1;
                    r_pass <= 1'b1;
                    r_comp <= '0;
                    r_state <= S_SQ;
                end
                S_OUT: begin
                    if (out_acc)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // mark the parity division so its end is told from a nudge division
            if (r_state == S_PLD)
                r_comp <= 2'd3;
        end
    end

    // result word straight from the working registers
    logic [SW+4:0] steps_w;
    assign steps_w        = {5'b0, r_steps};
    assign o_valid        = (r_state == S_OUT);
    assign o_stall        = (r_state != S_IDLE);
    assign o_out_x        = r_x;
    assign o_out_y        = r_y;
    assign o_out_z        = r_z;
    assign o_steps_taken  = (steps_w > (SW+5)'(31)) ? 5'd31 : steps_w[4:0];
    assign o_embed_failed = r_failed;

`include "mesh_distance_parity_embedder_core_assert.svh"
    `MDPE_ASSERT_IMP(a_steps_bound, 1'b1, r_steps <= SW'(MAX_STEPS))
    `MDPE_ASSERT_NXT(a_one_word, out_acc, !o_valid)
    `MDPE_ASSERT_IMP(a_div_count, (r_state == S_DIV || r_state == S_SQRT), r_cnt != '0)
endmodule
`default_nettype wire
